/* hw/rtl/lpac_pkg.sv */
// Types, register indexes, constants and the exp2 step table of the peak compressor.
package lpac_pkg;

	// Sequencer states, one-hot.
	typedef enum logic [13:0] {
		ST_IDLE  = 14'd1,
		ST_ENV_A = 14'd2,
		ST_ENV_B = 14'd4,
		ST_NORM  = 14'd8,
		ST_LOG   = 14'd16,
		ST_THR   = 14'd32,
		ST_GRED  = 14'd64,
		ST_MK_A  = 14'd128,
		ST_MK_B  = 14'd256,
		ST_EXP   = 14'd512,
		ST_GAIN  = 14'd1024,
		ST_OUT_A = 14'd2048,
		ST_OUT_B = 14'd4096,
		ST_DONE  = 14'd8192
	} state_t;

	typedef logic [1:0] reg_index_t;

	localparam reg_index_t REG_AMOUNT   = 2'd0;
	localparam reg_index_t REG_ATTACK   = 2'd1;
	localparam reg_index_t REG_RELEASE  = 2'd2;
	localparam reg_index_t REG_CHANNELS = 2'd3;

	localparam logic [15:0] AMOUNT_RESET   = 16'd0;
	localparam logic [15:0] ATTACK_RESET   = 16'd65387;
	localparam logic [15:0] RELEASE_RESET  = 16'd65524;
	localparam logic [1:0]  CHANNELS_RESET = 2'd2;

	localparam logic [21:0] UNITY_GAIN = 22'h100000;
	localparam logic [21:0] GAIN_MAX   = 22'h3FFFFF;
	localparam logic [17:0] THRESH_K   = 18'd261247;
	localparam logic [14:0] MAKEUP_K   = 15'd26214;

	// 2^(2^-(k+1)) in Q1.30, one entry per fraction bit from the top.
	function automatic logic [30:0] exp2_tab(input logic [3:0] k);
		logic [30:0] v;
		unique case (k)
			4'd0:    v = 31'd1518500250;
			4'd1:    v = 31'd1276901417;
			4'd2:    v = 31'd1170923764;
			4'd3:    v = 31'd1121280436;
			4'd4:    v = 31'd1097253708;
			4'd5:    v = 31'd1085434106;
			4'd6:    v = 31'd1079572136;
			4'd7:    v = 31'd1076653033;
			4'd8:    v = 31'd1075196443;
			4'd9:    v = 31'd1074468888;
			4'd10:   v = 31'd1074105294;
			4'd11:   v = 31'd1073923544;
			4'd12:   v = 31'd1073832679;
			4'd13:   v = 31'd1073787251;
			4'd14:   v = 31'd1073764537;
			default: v = 31'd1073753181;
		endcase
		return v;
	endfunction

endpackage

/* hw/rtl/lpac_in_if.sv */
// Input frame channel: valid, ready and one sample per channel.
interface lpac_in_if #(parameter int SAMPLE_BITS = 24) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_0;
	logic signed [SAMPLE_BITS-1:0] sample_1;

	modport source(output valid, output sample_0, output sample_1, input ready);
	modport sink(input valid, input sample_0, input sample_1, output ready);
endinterface

/* hw/rtl/lpac_out_if.sv */
// Output frame channel: valid, ready, processed samples and the applied gain.
interface lpac_out_if #(parameter int SAMPLE_BITS = 24) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] out_sample_0;
	logic signed [SAMPLE_BITS-1:0] out_sample_1;
	logic [21:0]                   gain_applied;

	modport source(output valid, output out_sample_0, output out_sample_1,
		output gain_applied, input ready);
	modport sink(input valid, input out_sample_0, input out_sample_1,
		input gain_applied, output ready);
endinterface

/* hw/rtl/linked_peak_audio_compressor.sv */
// Linked peak compressor: envelope follower, log-domain gain computer and shared gain.
//
//   Channel   Dir   Handshake       Payload
//   in_ch     in    valid / ready   sample_0, sample_1
//   out_ch    out   valid / ready   out_sample_0, out_sample_1, gain_applied
//   cfg       in    cfg_we          cfg_index, cfg_wdata (write only)
//
// A bypassed frame (amount zero) goes from idle straight to done. Otherwise the length of a
// frame depends on the leading-one position p of the envelope plus two (1 to 32): the leading-one
// shift, the 16-step log2 squaring loop and the 16-step exp2 loop on the one multiplier
// set it. The slope divider runs one quotient bit a cycle beside the log2 loop.
// One frame is in work at a time; a new frame is taken while the last result waits in
// the output register. Reset is asynchronous and needs no clearing pass.
module linked_peak_audio_compressor #(
	parameter int MAX_CHANNELS = 2,
	parameter int SAMPLE_BITS  = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	lpac_in_if.sink     in_ch,
	lpac_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	localparam int PEAK_SHIFT = 32 - SAMPLE_BITS;
	localparam logic signed [67:0] SMAX = (68'sd1 <<< (SAMPLE_BITS - 1)) - 68'sd1;
	localparam logic signed [67:0] SMIN = -(68'sd1 <<< (SAMPLE_BITS - 1));

	lpac_pkg::state_t state_q;

	logic [15:0] amount_q, attack_q, release_q;
	logic [1:0]  channels_q;
	logic [31:0] env_q;

	logic signed [SAMPLE_BITS-1:0] s0_q, s1_q, o0_q, o1_q, out0_q, out1_q;
	logic        use2_q;
	logic [31:0] peak_q;
	logic [16:0] coef_q;
	logic [48:0] acc_env_q;
	logic [32:0] norm_q;
	logic [5:0]  pos_q;
	logic [30:0] m_q;
	logic [15:0] frac_q;
	logic [3:0]  step_q;
	logic [17:0] t_q;
	logic [18:0] gr_q;
	logic [32:0] tm_q;
	logic signed [21:0] g_q;
	logic [15:0] fsh_q;
	logic [31:0] acc_q;
	logic [21:0] gain_q;
	logic [21:0] gain_out_q;
	logic        out_valid_q;

	logic [18:0] div_rem_q;
	logic [15:0] slope_q;
	logic [4:0]  div_cnt_q;

	// Shared multiplier.
	logic signed [34:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [67:0] mul_p;

	// Peak detection on the incoming frame.
	logic [SAMPLE_BITS-1:0] mag0, mag1;
	logic [31:0] pk0, pk1, peak_in;
	logic        use2_in;

	assign use2_in = channels_q[1] && (MAX_CHANNELS >= 2);
	assign mag0 = in_ch.sample_0[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_ch.sample_0)
		: SAMPLE_BITS'(in_ch.sample_0);
	assign mag1 = in_ch.sample_1[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_ch.sample_1)
		: SAMPLE_BITS'(in_ch.sample_1);
	assign pk0 = 32'(mag0) << PEAK_SHIFT;
	assign pk1 = 32'(mag1) << PEAK_SHIFT;
	assign peak_in = (use2_in && (pk1 > pk0)) ? pk1 : pk0;

	logic in_xfer, out_xfer, load_out;
	assign in_ch.ready = (state_q == lpac_pkg::ST_IDLE);
	assign in_xfer = in_ch.valid && in_ch.ready;
	assign out_xfer = out_valid_q && out_ch.ready;
	assign load_out = (state_q == lpac_pkg::ST_DONE) && (!out_valid_q || out_ch.ready);

	// Divider for the ratio slope.
	logic [17:0] den;
	logic [18:0] div_r2;
	logic        div_ge;
	assign den = 18'd65536 + 18'(amount_q) + 18'({amount_q, 1'b0});
	assign div_r2 = {div_rem_q[17:0], 1'b0};
	assign div_ge = div_r2 >= {1'b0, den};

	// Datapath terms.
	logic [49:0] env_sum;
	logic [31:0] env_new;
	logic [62:0] rnd30;
	logic [31:0] v30;
	logic signed [22:0] lvl;
	logic signed [23:0] over;
	logic [18:0] over_pos;
	logic signed [21:0] g_new;
	logic signed [5:0]  ip;
	logic signed [7:0]  sh;
	logic [5:0]  sh_u;
	logic [39:0] g_rnd, g_shift;
	logic [21:0] gain_new;
	logic signed [67:0] o_rnd, o_q;
	logic signed [SAMPLE_BITS-1:0] o_sat;

	assign env_sum = 50'(acc_env_q) + 50'(mul_p[48:0]) + 50'd32768;
	assign env_new = env_sum[47:16];
	assign rnd30 = mul_p[62:0] + 63'd536870912;
	assign v30 = rnd30[61:30];
	assign lvl = {7'(8'(pos_q) - 8'd31), frac_q};
	assign over = 24'(lvl) + 24'(t_q);
	assign over_pos = (over > 24'sd0) ? over[18:0] : 19'd0;
	assign g_new = 22'(mul_p[48:32]) - 22'(gr_q);
	assign ip = g_q[21:16];
	assign sh = 8'sd10 - 8'(ip);
	assign sh_u = sh[5:0];
	assign g_rnd = 40'(acc_q) + (40'd1 << (sh_u - 6'd1));
	assign g_shift = g_rnd >> sh_u;

	always_comb begin
		if (sh <= 8'sd0) begin
			gain_new = lpac_pkg::GAIN_MAX;
		end else if (sh >= 8'sd40) begin
			gain_new = '0;
		end else if (g_shift > 40'(lpac_pkg::GAIN_MAX)) begin
			gain_new = lpac_pkg::GAIN_MAX;
		end else begin
			gain_new = g_shift[21:0];
		end
	end

	assign o_rnd = mul_p + 68'sd524288;
	assign o_q = o_rnd >>> 20;
	always_comb begin
		if (o_q > SMAX) begin
			o_sat = SMAX[SAMPLE_BITS-1:0];
		end else if (o_q < SMIN) begin
			o_sat = SMIN[SAMPLE_BITS-1:0];
		end else begin
			o_sat = o_q[SAMPLE_BITS-1:0];
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			lpac_pkg::ST_ENV_A: begin
				mul_a = 35'(coef_q);
				mul_b = 33'(env_q);
			end
			lpac_pkg::ST_ENV_B: begin
				mul_a = 35'(17'd65536 - coef_q);
				mul_b = 33'(peak_q);
			end
			lpac_pkg::ST_LOG: begin
				mul_a = 35'(m_q);
				mul_b = 33'(m_q);
			end
			lpac_pkg::ST_THR: begin
				mul_a = 35'(amount_q);
				mul_b = 33'(lpac_pkg::THRESH_K);
			end
			lpac_pkg::ST_GRED: begin
				mul_a = 35'(over_pos);
				mul_b = 33'(slope_q);
			end
			lpac_pkg::ST_MK_A: begin
				mul_a = 35'(t_q);
				mul_b = 33'(lpac_pkg::MAKEUP_K);
			end
			lpac_pkg::ST_MK_B: begin
				mul_a = 35'(tm_q);
				mul_b = 33'(slope_q);
			end
			lpac_pkg::ST_EXP: begin
				mul_a = 35'(acc_q);
				mul_b = 33'(lpac_pkg::exp2_tab(step_q));
			end
			lpac_pkg::ST_OUT_A: begin
				mul_a = 35'(s0_q);
				mul_b = 33'(gain_q);
			end
			lpac_pkg::ST_OUT_B: begin
				mul_a = 35'(s1_q);
				mul_b = 33'(gain_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amount_q   <= lpac_pkg::AMOUNT_RESET;
			attack_q   <= lpac_pkg::ATTACK_RESET;
			release_q  <= lpac_pkg::RELEASE_RESET;
			channels_q <= lpac_pkg::CHANNELS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lpac_pkg::REG_AMOUNT:   amount_q <= cfg_wdata;
				lpac_pkg::REG_ATTACK:   attack_q <= cfg_wdata;
				lpac_pkg::REG_RELEASE:  release_q <= cfg_wdata;
				lpac_pkg::REG_CHANNELS: channels_q <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lpac_pkg::ST_IDLE;
			env_q       <= '0;
			out_valid_q <= 1'b0;
			div_cnt_q   <= '0;
			step_q      <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
			if (in_xfer && amount_q != '0) begin
				div_cnt_q <= 5'd16;
			end else if (div_cnt_q != '0) begin
				div_cnt_q <= div_cnt_q - 5'd1;
			end
			unique case (state_q)
				lpac_pkg::ST_IDLE: begin
					if (in_xfer) begin
						state_q <= (amount_q == '0) ? lpac_pkg::ST_DONE : lpac_pkg::ST_ENV_A;
					end
				end
				lpac_pkg::ST_ENV_A: state_q <= lpac_pkg::ST_ENV_B;
				lpac_pkg::ST_ENV_B: begin
					env_q   <= env_new;
					state_q <= lpac_pkg::ST_NORM;
				end
				lpac_pkg::ST_NORM: begin
					if (norm_q[32]) begin
						step_q  <= '0;
						state_q <= lpac_pkg::ST_LOG;
					end
				end
				lpac_pkg::ST_LOG: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd15) begin
						state_q <= lpac_pkg::ST_THR;
					end
				end
				lpac_pkg::ST_THR:  state_q <= lpac_pkg::ST_GRED;
				lpac_pkg::ST_GRED: state_q <= lpac_pkg::ST_MK_A;
				lpac_pkg::ST_MK_A: state_q <= lpac_pkg::ST_MK_B;
				lpac_pkg::ST_MK_B: begin
					step_q  <= '0;
					state_q <= lpac_pkg::ST_EXP;
				end
				lpac_pkg::ST_EXP: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd15) begin
						state_q <= lpac_pkg::ST_GAIN;
					end
				end
				lpac_pkg::ST_GAIN:  state_q <= lpac_pkg::ST_OUT_A;
				lpac_pkg::ST_OUT_A: state_q <= lpac_pkg::ST_OUT_B;
				lpac_pkg::ST_OUT_B: state_q <= lpac_pkg::ST_DONE;
				lpac_pkg::ST_DONE: begin
					if (load_out) begin
						state_q <= lpac_pkg::ST_IDLE;
					end
				end
				default: state_q <= lpac_pkg::ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			s0_q      <= in_ch.sample_0;
			s1_q      <= in_ch.sample_1;
			o0_q      <= in_ch.sample_0;
			o1_q      <= in_ch.sample_1;
			use2_q    <= use2_in;
			peak_q    <= peak_in;
			coef_q    <= (peak_in > env_q) ? 17'(attack_q) : 17'(release_q);
			gain_q    <= lpac_pkg::UNITY_GAIN;
			div_rem_q <= 19'(amount_q) + 19'({amount_q, 1'b0});
		end else if (div_cnt_q != '0) begin
			div_rem_q <= div_ge ? div_r2 - {1'b0, den} : div_r2;
			slope_q   <= {slope_q[14:0], div_ge};
		end
		if (load_out) begin
			gain_out_q <= gain_q;
			out0_q     <= o0_q;
			out1_q     <= o1_q;
		end
		unique case (state_q)
			lpac_pkg::ST_ENV_A: acc_env_q <= mul_p[48:0];
			lpac_pkg::ST_ENV_B: begin
				norm_q <= 33'(env_new) + 33'd2;
				pos_q  <= 6'd32;
			end
			lpac_pkg::ST_NORM: begin
				// Walk the leading one up to the top bit, one place a cycle.
				if (norm_q[32]) begin
					m_q <= norm_q[32:2];
				end else begin
					norm_q <= {norm_q[31:0], 1'b0};
					pos_q  <= pos_q - 6'd1;
				end
			end
			lpac_pkg::ST_LOG: begin
				// Each squaring yields one fraction bit of the logarithm.
				if (v30[31]) begin
					m_q <= v30[31:1];
				end else begin
					m_q <= v30[30:0];
				end
				frac_q <= {frac_q[14:0], v30[31]};
			end
			lpac_pkg::ST_THR:  t_q <= mul_p[33:16];
			lpac_pkg::ST_GRED: gr_q <= mul_p[34:16];
			lpac_pkg::ST_MK_A: tm_q <= mul_p[32:0];
			lpac_pkg::ST_MK_B: begin
				g_q   <= g_new;
				fsh_q <= g_new[15:0];
				acc_q <= 32'h4000_0000;
			end
			lpac_pkg::ST_EXP: begin
				if (fsh_q[15]) begin
					acc_q <= v30;
				end
				fsh_q <= {fsh_q[14:0], 1'b0};
			end
			lpac_pkg::ST_GAIN:  gain_q <= gain_new;
			lpac_pkg::ST_OUT_A: o0_q <= o_sat;
			lpac_pkg::ST_OUT_B: begin
				if (use2_q) begin
					o1_q <= o_sat;
				end
			end
			default: ;
		endcase
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.out_sample_0 = out0_q;
	assign out_ch.out_sample_1 = out1_q;
	assign out_ch.gain_applied = gain_out_q;

	// The slope quotient must be complete before the gain computer reads it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lpac_pkg::ST_THR |-> div_cnt_q == '0)
		else $error("slope division still running at threshold step");

	// The log2 mantissa stays normalized to [1, 2) through the squaring loop.
	a_log_norm: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lpac_pkg::ST_LOG |-> m_q[30])
		else $error("log2 mantissa lost normalization");

	// The envelope plus floor is at least two, so the leading-one walk stops early.
	a_norm_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lpac_pkg::ST_NORM |-> pos_q != '0)
		else $error("leading-one search ran past bit zero");

	// A result leaves the sequencer only into a free or draining output register.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q && $stable(gain_out_q)
			&& $stable(out0_q) && $stable(out1_q))
		else $error("waiting result overwritten");

endmodule

/* dv/lpac_tb_if.sv */
// Testbench constants: the cycle limit of the run.
package lpac_tb_pkg;
	localparam int FRAME_LIMIT = 4000000;
endpackage

/* dv/linked_peak_audio_compressor_tb.sv */
// Self-checking testbench of the linked peak compressor: directed and random frames and settings against a predictor.
module linked_peak_audio_compressor_tb;

	typedef struct packed {
		logic signed [23:0] s0;
		logic signed [23:0] s1;
	} frame_t;

	typedef struct packed {
		logic signed [23:0] o0;
		logic signed [23:0] o1;
		logic [21:0]        gain;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = lpac_pkg::REG_AMOUNT;
	logic [15:0] cfg_wdata = '0;

	lpac_in_if #(.SAMPLE_BITS(24)) in_ch();
	lpac_out_if #(.SAMPLE_BITS(24)) out_ch();

	linked_peak_audio_compressor #(.MAX_CHANNELS(2), .SAMPLE_BITS(24)) u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor copy of the registers and envelope.
	logic [15:0] p_amount, p_attack, p_release;
	logic [1:0]  p_chan;
	logic [31:0] p_env;

	frame_t  pending_frames[$];
	result_t expected_frames[$];
	int errors = 0;
	longint cycles = 0;
	bit hold_sink = 0;

	function automatic longint log2_q16(input longint unsigned x);
		int pos;
		longint unsigned t, m;
		int unsigned frac;
		pos = 0; t = x; frac = 0;
		while (t > 1) begin
			t = t >> 1;
			pos++;
		end
		m = (pos >= 30) ? (x >> (pos - 30)) : (x << (30 - pos));
		for (int k = 0; k < 16; k++) begin
			m = (m * m + (64'd1 << 29)) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		return longint'(pos - 31) * 65536 + longint'(frac);
	endfunction

	function automatic longint unsigned pow2_frac(input logic [15:0] f);
		longint unsigned acc;
		acc = 64'd1 << 30;
		for (int k = 0; k < 16; k++)
			if (f[15 - k])
				acc = (acc * longint'(lpac_pkg::exp2_tab(k[3:0])) + (64'd1 << 29)) >> 30;
		return acc;
	endfunction

	function automatic result_t compress_frame(input frame_t f);
		result_t r;
		longint s[2];
		longint unsigned peak, env, coef, thr, slope, mk, gr, gb, acc, gain, mag;
		longint lvl, over, g, p, q;
		int n_use, ip, sh;
		s[0] = f.s0; s[1] = f.s1;
		r.o0 = f.s0; r.o1 = f.s1; r.gain = lpac_pkg::UNITY_GAIN;
		if (p_amount == 0) return r;
		n_use = (p_chan < 1) ? 1 : ((p_chan > 2) ? 2 : p_chan);
		peak = 0; gr = 0;
		for (int c = 0; c < n_use; c++) begin
			mag = (s[c] < 0) ? -s[c] : s[c];
			mag = mag << 8;
			if (mag > peak) peak = mag;
		end
		env = p_env;
		coef = (peak > env) ? 64'(p_attack) : 64'(p_release);
		env = (coef * env + (65536 - coef) * peak + 32768) >> 16;
		p_env = env[31:0];
		lvl = log2_q16(env + 2);
		thr = (longint'(p_amount) * 261247) >> 16;
		slope = (3 * longint'(p_amount) * 65536) / (65536 + 3 * longint'(p_amount));
		over = lvl + longint'(thr);
		if (over > 0) gr = (longint'(over) * slope) >> 16;
		mk = (thr * slope * 26214) >> 32;
		g = longint'(mk) - longint'(gr);
		gb = g + 64 * 65536;
		ip = int'(gb >> 16) - 64;
		acc = pow2_frac(gb[15:0]);
		sh = 10 - ip;
		if (sh <= 0) gain = lpac_pkg::GAIN_MAX;
		else if (sh >= 40) gain = 0;
		else gain = (acc + (64'd1 << (sh - 1))) >> sh;
		if (gain > lpac_pkg::GAIN_MAX) gain = lpac_pkg::GAIN_MAX;
		r.gain = gain[21:0];
		for (int c = 0; c < n_use; c++) begin
			p = s[c] * longint'(gain);
			q = (p + (64'sd1 << 19)) >>> 20;
			if (q > 8388607) q = 8388607;
			if (q < -8388608) q = -8388608;
			if (c == 0) r.o0 = q[23:0];
			else r.o1 = q[23:0];
		end
		return r;
	endfunction

	// Driver: one wait per frame, drawn when the previous transfer completes.
	int gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.sample_0 <= '0;
			in_ch.sample_1 <= '0;
			gap <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				expected_frames.push_back(compress_frame({in_ch.sample_0, in_ch.sample_1}));
				void'(pending_frames.pop_front());
			end
			if (in_ch.valid && !in_ch.ready) begin
			end else if (gap > 0) begin
				in_ch.valid <= 1'b0;
				gap <= gap - 1;
			end else if ((in_ch.valid && in_ch.ready ? pending_frames.size() > 0
					: pending_frames.size() > 0)) begin
				if (in_ch.valid && in_ch.ready) begin
					in_ch.valid <= 1'b0;
					gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
				end else begin
					in_ch.valid <= 1'b1;
					in_ch.sample_0 <= pending_frames[0].s0;
					in_ch.sample_1 <= pending_frames[0].s1;
				end
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Monitor and receiver stalls.
	int stall = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall <= 0;
		end else begin
			cycles <= cycles + 1;
			if (out_ch.valid && out_ch.ready) begin
				if (expected_frames.size() == 0) begin
					$error("unexpected result frame");
					errors++;
				end else begin
					if (out_ch.out_sample_0 !== expected_frames[0].o0) begin
						$error("out_sample_0 expected %0d actual %0d",
							expected_frames[0].o0, out_ch.out_sample_0);
						errors++;
					end
					if (out_ch.out_sample_1 !== expected_frames[0].o1) begin
						$error("out_sample_1 expected %0d actual %0d",
							expected_frames[0].o1, out_ch.out_sample_1);
						errors++;
					end
					if (out_ch.gain_applied !== expected_frames[0].gain) begin
						$error("gain_applied expected %0h actual %0h",
							expected_frames[0].gain, out_ch.gain_applied);
						errors++;
					end
					void'(expected_frames.pop_front());
				end
			end
			if (hold_sink) begin
				out_ch.ready <= 1'b0;
			end else if (stall > 0) begin
				out_ch.ready <= 1'b0;
				stall <= stall - 1;
			end else if (out_ch.valid && out_ch.ready) begin
				if ($urandom_range(0, 3) == 0) begin
					out_ch.ready <= 1'b1;
				end else begin
					out_ch.ready <= 1'b0;
					stall <= $urandom_range(0, 15);
				end
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > lpac_tb_pkg::FRAME_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_frames.size() > 0 || expected_frames.size() > 0 || in_ch.valid)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			lpac_pkg::REG_AMOUNT:   p_amount = val;
			lpac_pkg::REG_ATTACK:   p_attack = val;
			lpac_pkg::REG_RELEASE:  p_release = val;
			default:                p_chan = val[1:0];
		endcase
	endtask

	function automatic logic signed [23:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return 24'($urandom_range(0, 255) - 128);
			3: return ($urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000)
				^ 24'($urandom_range(0, 4095));
			default: return 24'($urandom());
		endcase
	endfunction

	task automatic queue_random(input int n);
		frame_t f;
		for (int i = 0; i < n; i++) begin
			f.s0 = rand_sample();
			f.s1 = rand_sample();
			pending_frames.push_back(f);
		end
	endtask

	function automatic logic [15:0] pick16(input int k);
		case (k % 4)
			0: return 16'hFFFF;
			1: return 16'd1;
			default: return 16'($urandom());
		endcase
	endfunction

	initial begin
		frame_t f;
		p_amount = lpac_pkg::AMOUNT_RESET; p_attack = lpac_pkg::ATTACK_RESET;
		p_release = lpac_pkg::RELEASE_RESET; p_chan = lpac_pkg::CHANNELS_RESET; p_env = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: bypass first, then extremes at full amount in both channel modes, then at amount one.
		f.s0 = 24'sh7FFFFF; f.s1 = 24'sh800000; pending_frames.push_back(f);
		f.s0 = 24'sh800000; f.s1 = 24'sh7FFFFF; pending_frames.push_back(f);
		wait_drained();
		write_reg(lpac_pkg::REG_AMOUNT, 16'hFFFF);
		write_reg(lpac_pkg::REG_ATTACK, 16'd0);
		write_reg(lpac_pkg::REG_RELEASE, 16'hFFFF);
		f.s0 = 24'sd0; f.s1 = 24'sd0; pending_frames.push_back(f);
		f.s0 = 24'sh7FFFFF; f.s1 = 24'sd1; pending_frames.push_back(f);
		f.s0 = -24'sd1; f.s1 = 24'sh800000; pending_frames.push_back(f);
		f.s0 = 24'sh800000; f.s1 = 24'sh800000; pending_frames.push_back(f);
		f.s0 = 24'sd5; f.s1 = -24'sd5; pending_frames.push_back(f);
		wait_drained();
		write_reg(lpac_pkg::REG_CHANNELS, 16'd1);
		f.s0 = 24'sd3; f.s1 = 24'sh800000; pending_frames.push_back(f);
		f.s0 = 24'sh7FFFFF; f.s1 = 24'sh7FFFFF; pending_frames.push_back(f);
		wait_drained();
		write_reg(lpac_pkg::REG_CHANNELS, 16'd0);
		f.s0 = -24'sd100; f.s1 = 24'sh7FFFFF; pending_frames.push_back(f);
		wait_drained();
		write_reg(lpac_pkg::REG_AMOUNT, 16'd1);
		write_reg(lpac_pkg::REG_CHANNELS, 16'd3);
		f.s0 = 24'sh7FFFFF; f.s1 = 24'sh800000; pending_frames.push_back(f);
		f.s0 = 24'sd1; f.s1 = 24'sd1; pending_frames.push_back(f);
		wait_drained();

		// Receiver holds off while the sender keeps offering frames.
		hold_sink <= 1'b1;
		queue_random(10);
		repeat (600) @(posedge clk);
		hold_sink <= 1'b0;
		wait_drained();

		for (int ph = 0; ph < 14; ph++) begin
			write_reg(lpac_pkg::REG_AMOUNT, (ph % 5 == 4) ? 16'd0 : pick16(ph));
			write_reg(lpac_pkg::REG_ATTACK, pick16(ph + 1));
			write_reg(lpac_pkg::REG_RELEASE, pick16(ph + 2));
			write_reg(lpac_pkg::REG_CHANNELS, 16'($urandom_range(0, 3)));
			queue_random(80);
			wait_drained();
		end

		if (errors == 0 && expected_frames.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

/* files.f */
hw/rtl/lpac_pkg.sv
hw/rtl/lpac_in_if.sv
hw/rtl/lpac_out_if.sv
hw/rtl/linked_peak_audio_compressor.sv
dv/lpac_tb_if.sv
dv/linked_peak_audio_compressor_tb.sv
